/* rtl/i2cds_pkg.sv */
// Shared types, widths, register indexes and divider ROM for the I2C divider search.
package i2cds_pkg;

    localparam int KHZ_W      = 18;
    localparam int MHZ_W      = 8;
    localparam int TARGET_W   = 16;
    localparam int REQ_NS_W   = 24;
    localparam int MULT_W     = 2;
    localparam int ROW_W      = 6;
    localparam int DIVISOR_W  = 14;
    localparam int QUOT_W     = KHZ_W;
    localparam int PROD_W     = REQ_NS_W + MHZ_W;
    localparam int HOLD_NS_W  = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = KHZ_W;

    localparam int DEF_MULT_CHOICES = 3;
    localparam int DEF_DIVIDER_ROWS = 64;
    localparam int ROM_ROWS         = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_BUS_KHZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_MHZ = 2'd1;

    localparam logic [KHZ_W-1:0] BUS_KHZ_RESET = 18'd50000;
    localparam logic [MHZ_W-1:0] BUS_MHZ_RESET = 8'd50;

    typedef struct packed {
        logic [TARGET_W-1:0] target_rate_khz;
        logic [REQ_NS_W-1:0] min_data_hold_ns;
        logic [REQ_NS_W-1:0] min_start_hold_ns;
        logic [REQ_NS_W-1:0] min_stop_hold_ns;
    } req_t;

    typedef struct packed {
        logic [MULT_W-1:0] mult_code;
        logic [ROW_W-1:0]  divider_index;
        logic              found;
    } rsp_t;

    // divider in bus clocks, then data, start and stop hold in bus clocks
    typedef struct packed {
        logic [11:0] scl_div;
        logic [9:0]  data_hold;
        logic [10:0] start_hold;
        logic [10:0] stop_hold;
    } div_row_t;

    localparam div_row_t DIV_ROM [ROM_ROWS] = '{
        '{20, 7, 6, 11}, '{22, 7, 7, 12}, '{24, 8, 8, 13}, '{26, 8, 9, 14},
        '{28, 9, 10, 15}, '{30, 9, 11, 16}, '{34, 10, 13, 18}, '{40, 10, 16, 21},
        '{28, 7, 10, 15}, '{32, 7, 12, 17}, '{36, 9, 14, 19}, '{40, 9, 16, 21},
        '{44, 11, 18, 23}, '{48, 11, 20, 25}, '{56, 13, 24, 29}, '{68, 13, 30, 35},
        '{48, 9, 18, 25}, '{56, 9, 22, 29}, '{64, 13, 26, 33}, '{72, 13, 30, 37},
        '{80, 17, 34, 41}, '{88, 17, 38, 45}, '{104, 21, 46, 53}, '{128, 21, 58, 65},
        '{80, 9, 38, 41}, '{96, 9, 46, 49}, '{112, 17, 54, 57}, '{128, 17, 62, 65},
        '{144, 25, 70, 73}, '{160, 25, 78, 81}, '{192, 33, 94, 97}, '{240, 33, 118, 121},
        '{160, 17, 78, 81}, '{192, 17, 94, 97}, '{224, 33, 110, 113}, '{256, 33, 126, 129},
        '{288, 49, 142, 145}, '{320, 49, 158, 161}, '{384, 65, 190, 193},
        '{480, 65, 238, 241},
        '{320, 33, 158, 161}, '{384, 33, 190, 193}, '{448, 65, 222, 225},
        '{512, 65, 254, 257},
        '{576, 97, 286, 289}, '{640, 97, 318, 321}, '{768, 129, 382, 385},
        '{960, 129, 478, 481},
        '{640, 65, 318, 321}, '{768, 65, 382, 385}, '{896, 129, 446, 449},
        '{1024, 129, 510, 513},
        '{1152, 193, 574, 577}, '{1280, 193, 638, 641}, '{1536, 257, 766, 769},
        '{1920, 257, 958, 961},
        '{1280, 129, 638, 641}, '{1536, 129, 766, 769}, '{1792, 257, 894, 897},
        '{2048, 257, 1022, 1025},
        '{2304, 385, 1150, 1153}, '{2560, 385, 1278, 1281}, '{3072, 513, 1534, 1537},
        '{3840, 513, 1918, 1921}
    };

endpackage

/* rtl/i2c_divider_search_top.sv */
// Top level: I2C divider search over multiplier codes and divider ROM rows.
// Hold products are built by shift-add over the bits of bus_clock_mhz; every candidate is
// rated by the bit-serial rate divider. One item is searched at a time;
// the next is accepted the cycle after the result is loaded into the output register.
// Reset (rst_n, async, active low) clears control state and sets 50000 kHz / 50 MHz.
module i2c_divider_search_top
    import i2cds_pkg::*;
#(
    parameter int MULT_CHOICES = DEF_MULT_CHOICES,
    parameter int DIVIDER_ROWS = DEF_DIVIDER_ROWS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam int MCNT_W = $clog2(MHZ_W);
    localparam logic [MCNT_W-1:0] LAST_MHZ_BIT = MCNT_W'(MHZ_W - 1);
    localparam logic [MULT_W-1:0] LAST_MULT    = MULT_W'(MULT_CHOICES - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW     = ROW_W'(DIVIDER_ROWS - 1);
    localparam logic [HOLD_NS_W-1:0] NS_PER_US = HOLD_NS_W'(1000);

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [KHZ_W-1:0]     bus_khz_reg;
    logic [MHZ_W-1:0]     bus_mhz_reg;
    req_t                 req_reg;
    logic [MHZ_W-1:0]     mhz_sh_reg;
    logic [MCNT_W-1:0]    mcnt_reg;
    logic [PROD_W-1:0]    prod_data_reg;
    logic [PROD_W-1:0]    prod_start_reg;
    logic [PROD_W-1:0]    prod_stop_reg;
    logic [HOLD_NS_W-1:0] ns_data_reg;
    logic [HOLD_NS_W-1:0] ns_start_reg;
    logic [HOLD_NS_W-1:0] ns_stop_reg;
    logic [MULT_W-1:0]    mult_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [QUOT_W-1:0]    best_err_reg;
    logic [MULT_W-1:0]    best_mult_reg;
    logic [ROW_W-1:0]     best_row_reg;
    logic                 found_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    div_row_t             rom_row;
    logic [DIVISOR_W-1:0] divisor;
    logic                 div_start;
    logic                 div_done;
    logic [QUOT_W-1:0]    rate;
    logic [QUOT_W-1:0]    target_ext;
    logic [QUOT_W-1:0]    err;
    logic                 hold_ok;
    logic                 take;
    logic                 req_take;
    logic                 rsp_free;

    assign rom_row   = DIV_ROM[row_reg];
    assign divisor   = DIVISOR_W'(rom_row.scl_div) << mult_reg;
    assign div_start = state_reg == S_LOAD;

    i2cds_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (bus_khz_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (rate)
    );

    assign target_ext = QUOT_W'(req_reg.target_rate_khz);
    assign err = (rate >= target_ext) ? rate - target_ext : target_ext - rate;

    // a hold fails when the achieved time in ns is below requirement times MHz
    assign hold_ok =
        ((req_reg.min_data_hold_ns == '0) || (PROD_W'(ns_data_reg) >= prod_data_reg)) &&
        ((req_reg.min_start_hold_ns == '0) || (PROD_W'(ns_start_reg) >= prod_start_reg)) &&
        ((req_reg.min_stop_hold_ns == '0) || (PROD_W'(ns_stop_reg) >= prod_stop_reg));

    assign take     = hold_ok && (!found_reg || (err < best_err_reg));
    assign req_take = req_valid && !req_stall;
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mcnt_reg == LAST_MHZ_BIT)
                    state_next = S_LOAD;
            end
            S_LOAD:
                state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (row_reg == LAST_ROW && mult_reg == LAST_MULT)
                    state_next = S_DONE;
                else
                    state_next = S_LOAD;
            end
            S_DONE:
            begin
                if (rsp_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bus_khz_reg   <= BUS_KHZ_RESET;
            bus_mhz_reg   <= BUS_MHZ_RESET;
            mcnt_reg      <= '0;
            mult_reg      <= '0;
            row_reg       <= '0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BUS_KHZ: bus_khz_reg <= cfg_data;
                    CFG_BUS_MHZ: bus_mhz_reg <= cfg_data[MHZ_W-1:0];
                    default: ;
                endcase
            end
            if (req_take)
            begin
                mcnt_reg  <= '0;
                mult_reg  <= '0;
                row_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (state_reg == S_MUL)
                mcnt_reg <= mcnt_reg + 1'b1;
            if (state_reg == S_EVAL)
            begin
                if (take)
                    found_reg <= 1'b1;
                // advance row, then multiplier code
                if (row_reg == LAST_ROW)
                begin
                    row_reg <= '0;
                    if (mult_reg != LAST_MULT)
                        mult_reg <= mult_reg + 1'b1;
                end
                else
                    row_reg <= row_reg + 1'b1;
            end
            if (state_reg == S_DONE && rsp_free)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg        <= req;
            mhz_sh_reg     <= bus_mhz_reg;
            prod_data_reg  <= '0;
            prod_start_reg <= '0;
            prod_stop_reg  <= '0;
            best_err_reg   <= '0;
            best_mult_reg  <= '0;
            best_row_reg   <= '0;
        end
        if (state_reg == S_MUL)
        begin
            // shift-add, MSB of bus_clock_mhz first
            prod_data_reg  <= {prod_data_reg[PROD_W-2:0], 1'b0} +
                (mhz_sh_reg[MHZ_W-1] ? PROD_W'(req_reg.min_data_hold_ns) : '0);
            prod_start_reg <= {prod_start_reg[PROD_W-2:0], 1'b0} +
                (mhz_sh_reg[MHZ_W-1] ? PROD_W'(req_reg.min_start_hold_ns) : '0);
            prod_stop_reg  <= {prod_stop_reg[PROD_W-2:0], 1'b0} +
                (mhz_sh_reg[MHZ_W-1] ? PROD_W'(req_reg.min_stop_hold_ns) : '0);
            mhz_sh_reg     <= {mhz_sh_reg[MHZ_W-2:0], 1'b0};
        end
        if (state_reg == S_LOAD)
        begin
            ns_data_reg  <= (HOLD_NS_W'(rom_row.data_hold) * NS_PER_US) << mult_reg;
            ns_start_reg <= (HOLD_NS_W'(rom_row.start_hold) * NS_PER_US) << mult_reg;
            ns_stop_reg  <= (HOLD_NS_W'(rom_row.stop_hold) * NS_PER_US) << mult_reg;
        end
        if (state_reg == S_EVAL && take)
        begin
            best_err_reg  <= err;
            best_mult_reg <= mult_reg;
            best_row_reg  <= row_reg;
        end
        if (state_reg == S_DONE && rsp_free)
        begin
            rsp_reg.mult_code     <= best_mult_reg;
            rsp_reg.divider_index <= best_row_reg;
            rsp_reg.found         <= found_reg;
        end
    end

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* rtl/i2cds_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
module i2cds_div
    import i2cds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [QUOT_W-1:0]    dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [QUOT_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(QUOT_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    assign shifted = {rem_reg, quot_reg[QUOT_W-1]};
    assign trial   = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_BIT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            // shift dividend bits out the top, quotient bits in the bottom
            rem_reg  <= fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* rtl/i2cds_checker.sv */
// Port-level checks for the I2C divider search, bound to the top level.
module i2cds_checker
    import i2cds_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    localparam logic [MULT_W-1:0] BAD_MULT = '1;

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // no match reports zero setting
    a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.mult_code == '0 && rsp.divider_index == '0)
        else $error("no-match result carries a nonzero setting");

    a_mult_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.mult_code != BAD_MULT)
        else $error("multiplier code out of range");

    // the search occupies the block right after an accepted beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("input taken again while search in progress");

endmodule

bind i2c_divider_search_top i2cds_checker u_i2cds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
